// ----- rtl/cbc_pkg.sv -----
// Shared types and constants of the cluster box cover block.
package cbc_pkg;

  localparam int COORD_W = 16;
  localparam int SIZE_W  = 16;

  localparam logic [SIZE_W-1:0] BOX_SIZE_RESET = 16'd256;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [SIZE_W-1:0]         box_size_t;

  typedef struct packed {
    coord_t y;
    coord_t x;
  } centre_t;

  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } mem_ctl_t;

endpackage

// ----- rtl/cbc_point_if.sv -----
// Point request channel: valid, ready and the point payload.
interface cbc_point_if;
  logic                 valid;
  logic                 ready;
  cbc_pkg::coord_t      point_x;
  cbc_pkg::coord_t      point_y;
  logic                 cluster_start;

  modport source (output valid, output point_x, output point_y, output cluster_start,
                  input ready);
  modport sink (input valid, input point_x, input point_y, input cluster_start,
                output ready);
endinterface

// ----- rtl/cbc_box_if.sv -----
// Box centre request channel: valid, ready and the centre payload.
interface cbc_box_if;
  logic            valid;
  logic            ready;
  cbc_pkg::coord_t box_x;
  cbc_pkg::coord_t box_y;
  logic            store_full;

  modport source (output valid, output box_x, output box_y, output store_full,
                  input ready);
  modport sink (input valid, input box_x, input box_y, input store_full,
                output ready);
endinterface

// ----- rtl/cbc_centre_mem.sv -----
// Centre store: one write port and one registered read port.
module cbc_centre_mem #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic               clk,
  input  cbc_pkg::mem_ctl_t  ctl,
  input  logic [AW-1:0]      wr_addr,
  input  cbc_pkg::centre_t   wr_data,
  input  logic [AW-1:0]      rd_addr,
  output cbc_pkg::centre_t   rd_data
);

  cbc_pkg::centre_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (ctl.rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- rtl/cbc_box_test.sv -----
// Shared box test unit: strict square test of a point against one centre.
module cbc_box_test (
  input  cbc_pkg::coord_t    point_x,
  input  cbc_pkg::coord_t    point_y,
  input  cbc_pkg::centre_t   centre,
  input  cbc_pkg::box_size_t box_size,
  output logic               covered
);

  logic signed [cbc_pkg::COORD_W:0] dx;
  logic signed [cbc_pkg::COORD_W:0] dy;
  logic [cbc_pkg::COORD_W:0]        adx;
  logic [cbc_pkg::COORD_W:0]        ady;
  logic [cbc_pkg::COORD_W+1:0]      lim;

  always_comb begin
    dx  = {point_x[cbc_pkg::COORD_W-1], point_x} - {centre.x[cbc_pkg::COORD_W-1], centre.x};
    dy  = {point_y[cbc_pkg::COORD_W-1], point_y} - {centre.y[cbc_pkg::COORD_W-1], centre.y};
    adx = dx[cbc_pkg::COORD_W] ? (~dx + 1'b1) : dx;
    ady = dy[cbc_pkg::COORD_W] ? (~dy + 1'b1) : dy;
    lim = {2'b00, box_size};
    covered = ({adx, 1'b0} < lim) && ({ady, 1'b0} < lim);
  end

endmodule

// ----- rtl/cluster_box_cover.sv -----
// Top level of the cluster box cover block: sequencer, box size register and outputs.
//
//   channel  direction  handshake          payload
//   in_pt    in         valid / ready      point_x, point_y, cluster_start
//   out_box  out        valid / ready      box_x, box_y, store_full
//   cfg      in         cfg_wr_en          cfg_wr_data (box_size)
//
// A point passes an accept step (S_IDLE), a scan (S_SCAN) of the N stored centres of
// its cluster (one read of the centre store per cycle through the shared box test),
// and a store-and-emit step (S_DECIDE).
// A cluster start or an empty store skips the scan. The scan stops at the first hit.
// Reset empties the store through the centre count; no clearing pass.
// A waiting result holds the emit step but not the next accept.
module cluster_box_cover #(
  parameter int MAX_BOXES = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wr_en,
  input  cbc_pkg::box_size_t  cfg_wr_data,
  cbc_point_if.sink           in_pt,
  cbc_box_if.source           out_box
);

  localparam int AW = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
  localparam int CW = $clog2(MAX_BOXES + 1);
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_BOXES);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE
  } state_t;

  state_t             state_r;
  cbc_pkg::box_size_t box_size_r;
  cbc_pkg::centre_t   point_r;
  logic [CW-1:0]      count_r;
  logic [CW-1:0]      idx_r;
  logic               pending_r;
  logic               out_valid_r;
  cbc_pkg::coord_t    out_x_r;
  cbc_pkg::coord_t    out_y_r;
  logic               out_full_r;

  cbc_pkg::mem_ctl_t  mem_ctl;
  cbc_pkg::centre_t   rd_data;
  logic               covered;
  logic               hit;
  logic               emit;

  assign hit  = pending_r && covered;
  assign emit = (state_r == S_DECIDE) && (!out_valid_r || out_box.ready);

  always_comb begin
    mem_ctl.rd_en = (state_r == S_SCAN) && !hit && (idx_r != count_r);
    mem_ctl.wr_en = emit && (count_r < MAX_CNT);
  end

  cbc_centre_mem #(
    .DEPTH (MAX_BOXES),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .ctl     (mem_ctl),
    .wr_addr (count_r[AW-1:0]),
    .wr_data (point_r),
    .rd_addr (idx_r[AW-1:0]),
    .rd_data (rd_data)
  );

  cbc_box_test u_test (
    .point_x  (point_r.x),
    .point_y  (point_r.y),
    .centre   (rd_data),
    .box_size (box_size_r),
    .covered  (covered)
  );

  assign in_pt.ready        = (state_r == S_IDLE);
  assign out_box.valid      = out_valid_r;
  assign out_box.box_x      = out_x_r;
  assign out_box.box_y      = out_y_r;
  assign out_box.store_full = out_full_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      box_size_r <= cbc_pkg::BOX_SIZE_RESET;
    end else if (cfg_wr_en) begin
      box_size_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      idx_r       <= '0;
      pending_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_box.ready && !emit) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_pt.valid) begin
            point_r.x <= in_pt.point_x;
            point_r.y <= in_pt.point_y;
            idx_r     <= '0;
            pending_r <= 1'b0;
            if (in_pt.cluster_start) begin
              count_r <= '0;
              state_r <= S_DECIDE;
            end else if (count_r == '0) begin
              state_r <= S_DECIDE;
            end else begin
              state_r <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (hit) begin
            pending_r <= 1'b0;
            state_r   <= S_IDLE;
          end else if (idx_r == count_r) begin
            pending_r <= 1'b0;
            state_r   <= S_DECIDE;
          end else begin
            idx_r     <= idx_r + 1'b1;
            pending_r <= 1'b1;
          end
        end
        S_DECIDE: begin
          if (emit) begin
            out_valid_r <= 1'b1;
            out_x_r     <= point_r.x;
            out_y_r     <= point_r.y;
            if (count_r < MAX_CNT) begin
              count_r    <= count_r + 1'b1;
              out_full_r <= 1'b0;
            end else begin
              out_full_r <= 1'b1;
            end
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- tb/tb_cluster_box_cover.sv -----
// Testbench for cluster_box_cover: directed and random point streams checked against a predictor.
`timescale 1ns / 100ps

module tb_cluster_box_cover;

  localparam int MAX_BOXES   = 64;
  localparam int SETTLE      = MAX_BOXES + 8;
  localparam int HOLD_CYCLES = 600;
  localparam int NUM_DIR     = 25;
  localparam int NUM_PHASES  = 8;

  typedef enum logic {ROW_POINT, ROW_SIZE} row_kind_t;
  typedef enum logic [1:0] {CHK_PREDICT, CHK_SILENT, CHK_CENTRE} check_t;

  typedef struct packed {
    row_kind_t kind;
    int        a;
    int        b;
    logic      start;
    check_t    chk;
  } stim_row_t;

  typedef struct packed {
    cbc_pkg::coord_t x;
    cbc_pkg::coord_t y;
    logic            full;
  } box_exp_t;

  logic clk;
  logic rst_n;
  logic cfg_wr_en;
  cbc_pkg::box_size_t cfg_wr_data;

  cbc_point_if pt();
  cbc_box_if   box();

  cluster_box_cover #(
    .MAX_BOXES(MAX_BOXES)
  ) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_pt      (pt),
    .out_box    (box)
  );

  cbc_pkg::centre_t   cover_store [MAX_BOXES];
  int                 cover_count;
  cbc_pkg::box_size_t box_size_q;
  box_exp_t           centre_q [$];
  int                 mismatches;
  bit                 burst;
  bit                 hold_req;
  bit                 hold_done;

  stim_row_t dir_tab [NUM_DIR] = '{
    '{ROW_POINT,      0,      0, 1'b0, CHK_CENTRE},
    '{ROW_POINT,    127,      0, 1'b0, CHK_SILENT},
    '{ROW_POINT,      0,   -127, 1'b0, CHK_SILENT},
    '{ROW_POINT,    128,      0, 1'b0, CHK_CENTRE},
    '{ROW_POINT,   -128,      0, 1'b0, CHK_CENTRE},
    '{ROW_POINT,   -200,    300, 1'b0, CHK_PREDICT},
    '{ROW_POINT,  32767,  32767, 1'b1, CHK_CENTRE},
    '{ROW_POINT,  32767,  32767, 1'b0, CHK_SILENT},
    '{ROW_POINT, -32768, -32768, 1'b0, CHK_CENTRE},
    '{ROW_POINT, -32768,  32767, 1'b0, CHK_CENTRE},
    '{ROW_POINT,  32767, -32768, 1'b0, CHK_CENTRE},
    '{ROW_POINT,      0,      0, 1'b1, CHK_CENTRE},
    '{ROW_POINT,  32767,  32767, 1'b0, CHK_CENTRE},
    '{ROW_SIZE,       0,      0, 1'b0, CHK_PREDICT},
    '{ROW_POINT,      5,      5, 1'b1, CHK_CENTRE},
    '{ROW_POINT,      5,      5, 1'b0, CHK_CENTRE},
    '{ROW_SIZE,   65535,      0, 1'b0, CHK_PREDICT},
    '{ROW_POINT,      0,      0, 1'b1, CHK_CENTRE},
    '{ROW_POINT,  16383, -16383, 1'b0, CHK_SILENT},
    '{ROW_POINT, -32768,  32767, 1'b0, CHK_CENTRE},
    '{ROW_POINT,  32767, -32767, 1'b0, CHK_PREDICT},
    '{ROW_SIZE,       1,      0, 1'b0, CHK_PREDICT},
    '{ROW_POINT,    100,   -100, 1'b1, CHK_CENTRE},
    '{ROW_POINT,    100,   -100, 1'b0, CHK_SILENT},
    '{ROW_POINT,    101,   -100, 1'b0, CHK_CENTRE}
  };

  function automatic bit cover_point(input cbc_pkg::coord_t px, input cbc_pkg::coord_t py,
                                     input logic first, output box_exp_t res);
    int dx;
    int dy;
    int edge_len;
    bit hit;
    hit = 1'b0;
    edge_len = box_size_q;
    res = '{x: px, y: py, full: 1'b0};
    if (first) begin
      cover_count = 0;
    end else begin
      for (int k = 0; k < cover_count; k++) begin
        dx = int'(px) - int'(cover_store[k].x);
        dy = int'(py) - int'(cover_store[k].y);
        if (dx < 0) dx = -dx;
        if (dy < 0) dy = -dy;
        if (2 * dx < edge_len && 2 * dy < edge_len) hit = 1'b1;
      end
    end
    if (hit) return 1'b0;
    if (cover_count < MAX_BOXES) begin
      cover_store[cover_count] = '{y: py, x: px};
      cover_count++;
    end else begin
      res.full = 1'b1;
    end
    return 1'b1;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic cbc_pkg::coord_t pick_coord();
    if ($urandom_range(0, 7) == 0) return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
    return cbc_pkg::coord_t'($urandom);
  endfunction

  task automatic log_mismatch(input string what, input box_exp_t want, input box_exp_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t mismatch (%s): expected x=%0d y=%0d full=%0b, got x=%0d y=%0d full=%0b",
               $realtime, what, want.x, want.y, want.full, got.x, got.y, got.full);
  endtask

  task automatic offer_point(input cbc_pkg::coord_t px, input cbc_pkg::coord_t py,
                             input logic first, input check_t chk);
    int gap;
    bit emits;
    box_exp_t res;
    gap = burst ? 0 : pick_gap();
    if (gap > 0) begin
      pt.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pt.valid         <= 1'b1;
    pt.point_x       <= px;
    pt.point_y       <= py;
    pt.cluster_start <= first;
    @(posedge clk);
    while (!pt.ready) @(posedge clk);
    emits = cover_point(px, py, first, res);
    unique case (chk)
      CHK_PREDICT: begin
        if (emits) centre_q = {centre_q, res};
      end
      CHK_CENTRE: begin
        res = '{x: px, y: py, full: 1'b0};
        centre_q = {centre_q, res};
      end
      default: ;
    endcase
  endtask

  task automatic write_box_size(input cbc_pkg::box_size_t value);
    pt.valid <= 1'b0;
    while (centre_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en  <= 1'b0;
    box_size_q = value;
  endtask

  task automatic offer_cluster(input int len, input int spread);
    cbc_pkg::coord_t cx;
    cbc_pkg::coord_t cy;
    cbc_pkg::coord_t px;
    cbc_pkg::coord_t py;
    logic first;
    int off;
    cx = pick_coord();
    cy = pick_coord();
    burst = ($urandom_range(0, 7) == 0);
    for (int k = 0; k < len; k++) begin
      if (k == 0) begin
        px = cx;
        py = cy;
        first = ($urandom_range(0, 19) != 0);
      end else if ($urandom_range(0, 9) == 0) begin
        px = cbc_pkg::coord_t'($urandom);
        py = cbc_pkg::coord_t'($urandom);
        first = ($urandom_range(0, 29) == 0);
      end else begin
        off = $urandom_range(0, 2 * spread);
        px = cbc_pkg::coord_t'(int'(cx) + off - spread);
        off = $urandom_range(0, 2 * spread);
        py = cbc_pkg::coord_t'(int'(cy) + off - spread);
        first = 1'b0;
      end
      offer_point(px, py, first, CHK_PREDICT);
    end
    burst = 1'b0;
  endtask

  task automatic offer_clusters(input int n_items);
    int sent;
    int len;
    int spread;
    sent = 0;
    while (sent < n_items) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 90) : $urandom_range(1, 30);
      spread = box_size_q;
      if (spread < 4) spread = 4;
      offer_cluster(len, spread);
      sent += len;
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #(40_000_000);
    $display("FAIL");
    $finish;
  end

  initial begin : result_side
    int n;
    box.ready = 1'b0;
    @(posedge clk);
    forever begin
      if (hold_req && !hold_done) begin
        box.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end else begin
        box.ready <= 1'b1;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(150, 300) : $urandom_range(1, 20);
        repeat (n) @(posedge clk);
        n = pick_gap();
        if (n > 0) begin
          box.ready <= 1'b0;
          repeat (n) @(posedge clk);
        end
      end
    end
  end

  always @(posedge clk) begin
    box_exp_t got;
    box_exp_t want;
    if (rst_n && box.valid && box.ready) begin
      got = '{x: box.box_x, y: box.box_y, full: box.store_full};
      if (centre_q.size() == 0) begin
        log_mismatch("unexpected box", '0, got);
      end else begin
        want = centre_q.pop_front();
        if (got.x !== want.x || got.y !== want.y || got.full !== want.full)
          log_mismatch("box fields", want, got);
      end
    end
  end

  initial begin : point_side
    cbc_pkg::box_size_t phase_size [NUM_PHASES];
    rst_n            = 1'b0;
    cfg_wr_en        = 1'b0;
    cfg_wr_data      = '0;
    pt.valid         = 1'b0;
    pt.point_x       = '0;
    pt.point_y       = '0;
    pt.cluster_start = 1'b0;
    cover_count      = 0;
    box_size_q       = cbc_pkg::BOX_SIZE_RESET;
    mismatches       = 0;
    burst            = 1'b0;
    hold_req         = 1'b0;
    hold_done        = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_tab[i]) begin
      if (dir_tab[i].kind == ROW_SIZE)
        write_box_size(cbc_pkg::box_size_t'(dir_tab[i].a));
      else
        offer_point(cbc_pkg::coord_t'(dir_tab[i].a), cbc_pkg::coord_t'(dir_tab[i].b),
                    dir_tab[i].start, dir_tab[i].chk);
    end

    write_box_size(16'd0);
    offer_cluster(70, 1000);
    write_box_size(16'd40);
    offer_cluster(120, 800);

    phase_size[0] = 16'd256;
    phase_size[1] = 16'hFFFF;
    phase_size[2] = 16'd0;
    phase_size[3] = 16'd1;
    phase_size[4] = cbc_pkg::box_size_t'($urandom_range(2, 1023));
    phase_size[5] = cbc_pkg::box_size_t'($urandom_range(1024, 65534));
    phase_size[6] = cbc_pkg::box_size_t'($urandom_range(2, 255));
    phase_size[7] = 16'h8000;
    foreach (phase_size[p]) begin
      write_box_size(phase_size[p]);
      if (p == 0) hold_req = 1'b1;
      offer_clusters(175);
    end

    pt.valid <= 1'b0;
    while (centre_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (mismatches == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/cbc_pkg.sv
rtl/cbc_point_if.sv
rtl/cbc_box_if.sv
rtl/cbc_centre_mem.sv
rtl/cbc_box_test.sv
rtl/cluster_box_cover.sv
tb/tb_cluster_box_cover.sv
